>>> hdl/gpm_pkg.sv
// ----------------------------------------------------------------------------
// Glob pattern match package
// Shared constants, sequencer states and the result record of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package gpm_pkg;

    localparam int CharW               = 8;
    localparam int PosW                = 6;
    localparam int WordW               = 64;
    localparam int CfgWords            = 4;
    localparam int CfgIdxW             = 2;
    localparam int CharsPerWord        = WordW / CharW;
    localparam int StoreCharsMax       = CfgWords * CharsPerWord;
    localparam int PatternCharsDefault = 32;
    localparam int OutDataW            = 8;

    localparam logic [PosW-1:0]  PosMax = 6'd63;

    localparam logic [CharW-1:0] ChNul  = 8'h00;
    localparam logic [CharW-1:0] ChAny  = 8'h3F;
    localparam logic [CharW-1:0] ChStar = 8'h2A;
    localparam logic [CharW-1:0] ChEsc  = 8'h5C;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_ESC,
        S_STAR,
        S_STAR_ESC,
        S_EMIT
    } gpm_state_t;

    typedef struct packed {
        logic valid;
        logic matched;
    } gpm_result_t;

endpackage

`default_nettype wire

>>> hdl/gpm_pattern_store.sv
// ----------------------------------------------------------------------------
// Pattern store
// Holds the pattern characters written through the configuration port and
// reads one of them per cycle; positions beyond the store read as NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_pattern_store #(
    parameter int PATTERN_CHARS = gpm_pkg::PatternCharsDefault
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gpm_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [gpm_pkg::WordW-1:0]   cfg_data,
    input  wire logic [gpm_pkg::PosW-1:0]    rd_pos,
    output logic      [gpm_pkg::CharW-1:0]   rd_char
);

    localparam int StoreChars = (PATTERN_CHARS < gpm_pkg::StoreCharsMax) ?
                                PATTERN_CHARS : gpm_pkg::StoreCharsMax;
    localparam int IdxW = $clog2(StoreChars);

    logic [gpm_pkg::CharW-1:0] char_reg [StoreChars];

    for (genvar i = 0; i < StoreChars; i++) begin : g_char
        localparam int WordIdx = i / gpm_pkg::CharsPerWord;
        localparam int ByteIdx = i % gpm_pkg::CharsPerWord;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                char_reg[i] <= '0;
            end
            else if (cfg_we && (cfg_index == gpm_pkg::CfgIdxW'(WordIdx))) begin
                char_reg[i] <= cfg_data[ByteIdx*gpm_pkg::CharW +: gpm_pkg::CharW];
            end
        end
    end

    always_comb begin
        if (rd_pos < gpm_pkg::PosW'(StoreChars)) begin
            rd_char = char_reg[rd_pos[IdxW-1:0]];
        end
        else begin
            rd_char = gpm_pkg::ChNul;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gpm_sequencer.sv
// ----------------------------------------------------------------------------
// Match sequencer
// Steps through the pattern one character per cycle for each name item,
// keeps the star and failure state and raises the verdict on the name's NUL.
// ----------------------------------------------------------------------------
`default_nettype none

module gpm_sequencer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [gpm_pkg::CharW-1:0] in_char,
    output logic      [gpm_pkg::PosW-1:0]  rd_pos,
    input  wire logic [gpm_pkg::CharW-1:0] rd_char,
    input  wire logic                      out_free,
    output gpm_pkg::gpm_result_t           rslt
);

    gpm_pkg::gpm_state_t state_reg, state_next;

    logic [gpm_pkg::CharW-1:0] char_reg, char_next;
    logic [gpm_pkg::PosW-1:0]  pos_reg, pos_next;
    logic [gpm_pkg::CharW-1:0] target_reg, target_next;
    logic                      star_wait_reg, star_wait_next;
    logic                      failed_reg, failed_next;
    logic                      verdict_reg, verdict_next;

    logic                      accept;
    logic                      in_nul;
    logic                      in_hit;
    logic                      c_nul;
    logic                      c_hit;
    logic                      p_skip;
    logic [gpm_pkg::PosW-1:0]  pos_bump;

    assign accept   = in_valid && (state_reg == gpm_pkg::S_IDLE);
    assign in_nul   = (in_char == gpm_pkg::ChNul);
    assign in_hit   = (in_char == target_reg);
    assign c_nul    = (char_reg == gpm_pkg::ChNul);
    assign c_hit    = (char_reg == rd_char);
    assign p_skip   = rd_char inside {gpm_pkg::ChStar, gpm_pkg::ChAny};
    assign pos_bump = (pos_reg == gpm_pkg::PosMax) ? pos_reg : pos_reg + 1'b1;
    assign rd_pos   = pos_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gpm_pkg::S_IDLE:
            begin
                if (accept) begin
                    if (failed_reg || star_wait_reg) begin
                        state_next = in_nul ? gpm_pkg::S_EMIT : gpm_pkg::S_IDLE;
                    end
                    else begin
                        state_next = gpm_pkg::S_EVAL;
                    end
                end
            end
            gpm_pkg::S_EVAL:
            begin
                if (rd_char == gpm_pkg::ChStar) begin
                    state_next = gpm_pkg::S_STAR;
                end
                else if (rd_char == gpm_pkg::ChEsc) begin
                    state_next = gpm_pkg::S_ESC;
                end
                else begin
                    state_next = c_nul ? gpm_pkg::S_EMIT : gpm_pkg::S_IDLE;
                end
            end
            gpm_pkg::S_STAR:
            begin
                if (p_skip) begin
                    state_next = gpm_pkg::S_STAR;
                end
                else if (rd_char == gpm_pkg::ChEsc) begin
                    state_next = gpm_pkg::S_STAR_ESC;
                end
                else begin
                    state_next = c_nul ? gpm_pkg::S_EMIT : gpm_pkg::S_IDLE;
                end
            end
            gpm_pkg::S_ESC,
            gpm_pkg::S_STAR_ESC:
            begin
                state_next = c_nul ? gpm_pkg::S_EMIT : gpm_pkg::S_IDLE;
            end
            gpm_pkg::S_EMIT:
            begin
                state_next = out_free ? gpm_pkg::S_IDLE : gpm_pkg::S_EMIT;
            end
            default:
            begin
                state_next = gpm_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        char_next      = char_reg;
        pos_next       = pos_reg;
        target_next    = target_reg;
        star_wait_next = star_wait_reg;
        failed_next    = failed_reg;
        verdict_next   = verdict_reg;
        in_ready       = 1'b0;
        rslt.valid     = 1'b0;
        rslt.matched   = verdict_reg;
        case (state_reg)
            gpm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept) begin
                    char_next    = in_char;
                    verdict_next = 1'b0;
                    if (!failed_reg && star_wait_reg && in_hit) begin
                        star_wait_next = 1'b0;
                        verdict_next   = 1'b1;
                    end
                end
            end
            gpm_pkg::S_EVAL:
            begin
                pos_next = pos_bump;
                if (rd_char == gpm_pkg::ChAny) begin
                    verdict_next = 1'b0;
                end
                else if (rd_char != gpm_pkg::ChStar && rd_char != gpm_pkg::ChEsc) begin
                    verdict_next = c_hit;
                    failed_next  = !c_hit && !c_nul;
                end
            end
            gpm_pkg::S_ESC:
            begin
                pos_next     = pos_bump;
                verdict_next = c_hit;
                failed_next  = !c_hit && !c_nul;
            end
            gpm_pkg::S_STAR:
            begin
                pos_next = pos_bump;
                if (!p_skip && rd_char != gpm_pkg::ChEsc) begin
                    target_next    = rd_char;
                    verdict_next   = c_hit;
                    star_wait_next = !c_hit;
                end
            end
            gpm_pkg::S_STAR_ESC:
            begin
                pos_next       = pos_bump;
                target_next    = rd_char;
                verdict_next   = c_hit;
                star_wait_next = !c_hit;
            end
            gpm_pkg::S_EMIT:
            begin
                if (out_free) begin
                    rslt.valid     = 1'b1;
                    pos_next       = '0;
                    target_next    = gpm_pkg::ChNul;
                    star_wait_next = 1'b0;
                    failed_next    = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= gpm_pkg::S_IDLE;
            pos_reg       <= '0;
            target_reg    <= '0;
            star_wait_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            target_reg    <= target_next;
            star_wait_reg <= star_wait_next;
            failed_reg    <= failed_next;
        end
    end

    always_ff @(posedge clk) begin
        char_reg    <= char_next;
        verdict_reg <= verdict_next;
    end

`ifndef SYNTHESIS
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        rslt.valid |=> (pos_reg == '0) && !failed_reg && !star_wait_reg)
        else $error("match state not cleared after a verdict");

    a_fail_excludes_star: assert property (@(posedge clk) disable iff (!rst_n)
        !(failed_reg && star_wait_reg))
        else $error("failure and star wait set together");

    a_pos_forward: assert property (@(posedge clk) disable iff (!rst_n)
        !rslt.valid |=> pos_reg >= $past(pos_reg))
        else $error("pattern position moved backwards without a verdict");

    a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gpm_pkg::S_EMIT) && !out_free |=> $stable(verdict_reg))
        else $error("pending verdict changed while stalled");
`endif

endmodule

`default_nettype wire

>>> hdl/glob_pattern_match_core.sv
// ----------------------------------------------------------------------------
// Glob pattern match core
// Matches a NUL-terminated stream of name characters against a stored glob
// pattern and gives one verdict item per name.
// ----------------------------------------------------------------------------
// A name character is normally first accepted and then compared with the
// pattern character at the current position. An escaped pattern character
// adds a further compare state, and a star walks over pattern characters to
// find its target, since the single pattern read port is stepped one
// character per cycle. While a star waits for its target, or after a
// mismatch, a character is handled in the accept state alone. The name's
// NUL passes the verdict through the emit state to the output register,
// which holds it until taken while the next name is already being accepted.
`default_nettype none

module glob_pattern_match_core #(
    parameter int PATTERN_CHARS = gpm_pkg::PatternCharsDefault
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gpm_pkg::CfgIdxW-1:0]    cfg_index,
    input  wire logic [gpm_pkg::WordW-1:0]      cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Bits 7:0 name_char.
    input  wire logic [gpm_pkg::CharW-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Bit 0 matched, bits 7:1 zero.
    output logic      [gpm_pkg::OutDataW-1:0]   m_tdata
);

    logic [gpm_pkg::PosW-1:0]  rd_pos;
    logic [gpm_pkg::CharW-1:0] rd_char;
    logic                      out_free;
    gpm_pkg::gpm_result_t      rslt;

    logic m_valid_reg, m_valid_next;
    logic m_match_reg, m_match_next;

    gpm_pattern_store #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .rd_pos   (rd_pos),
        .rd_char  (rd_char)
    );

    gpm_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_char (s_tdata),
        .rd_pos  (rd_pos),
        .rd_char (rd_char),
        .out_free(out_free),
        .rslt    (rslt)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_match_next = m_match_reg;
        if (rslt.valid) begin
            m_valid_next = 1'b1;
            m_match_next = rslt.matched;
        end
        else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
        end
        else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        m_match_reg <= m_match_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(gpm_pkg::OutDataW - 1)'(0), m_match_reg};

endmodule

`default_nettype wire
